>>> design/lus3_pkg.sv
`timescale 1ns / 1ps

package lus3_pkg;

    // operation codes of one input transaction
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_FACTOR = 2'd1;
    localparam logic [1:0] OP_SOLVE  = 2'd2;

    // number of matrix entries that a write may address
    localparam logic [3:0] NUM_ENTRIES = 4'd9;

    // input transaction payload
    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] rhs_0;
        logic signed [31:0] rhs_1;
        logic signed [31:0] rhs_2;
    } t_in;

    // output transaction payload
    typedef struct packed {
        logic               kind;
        logic signed [31:0] sol_0;
        logic signed [31:0] sol_1;
        logic signed [31:0] sol_2;
        logic [1:0]         first_row;
        logic [1:0]         second_row;
        logic [1:0]         third_row;
        logic               singular;
        logic               saturated;
    } t_out;

    // sequencer instruction codes
    typedef enum logic [3:0] {
        I_LDA,   // a = store[addr], pivot index cleared
        I_LDB,   // b = store[addr]
        I_STA,   // store[addr] = a
        I_STB,   // store[addr] = b
        I_MSUB,  // a = a - b * store[addr]
        I_DIV,   // a = a / store[addr]
        I_SEL,   // keep larger magnitude of a and store[addr], record arg
        I_JNE,   // jump when pivot index differs from arg
        I_JNZ,   // jump when a is not zero
        I_JMP,   // jump
        I_SING,  // note a zero pivot
        I_CLR,   // a = 0
        I_PSWAP, // swap two entries of the row order
        I_LDR,   // a = right-hand side element picked by row order
        I_OUT,   // solution element arg = a
        I_END    // finish, arg 0 factorize, arg 1 solve
    } t_icode;

    typedef enum logic [1:0] {
        EM_FACT,
        EM_SOLVE,
        EM_ZERO
    } t_emit;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_EXEC,
        S_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        t_icode     code;
        logic [3:0] addr;
        logic [1:0] arg;
        logic [6:0] tgt;
    } t_instr;

    // controller to datapath
    typedef struct packed {
        logic       go;
        t_icode     code;
        logic [3:0] addr;
        logic [1:0] arg;
        logic       start;
        logic       wr;
        logic       emit;
        t_emit      emit_kind;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       busy;
        logic       a_zero;
        logic [1:0] bi;
        logic       singular;
        logic       out_free;
    } t_stat;

    // program labels
    localparam logic [6:0] L_S02     = 7'd18;
    localparam logic [6:0] L_C0      = 7'd32;
    localparam logic [6:0] L_E0      = 7'd39;
    localparam logic [6:0] L_C1      = 7'd59;
    localparam logic [6:0] L_C1Z     = 7'd75;
    localparam logic [6:0] L_E1      = 7'd81;
    localparam logic [6:0] L_FEND    = 7'd91;
    localparam logic [6:0] PC_FACTOR = 7'd0;
    localparam logic [6:0] PC_SOLVE  = 7'd92;
    localparam int         PROG_LEN  = 126;

    // store layout: entries 0..8 matrix row major, 9..11 working vector
    localparam t_instr PROG [0:PROG_LEN-1] = '{
        // column 0 pivot search
        '{I_LDA,   4'd0,  2'd0, 7'd0},
        '{I_SEL,   4'd3,  2'd1, 7'd0},
        '{I_SEL,   4'd6,  2'd2, 7'd0},
        '{I_JNE,   4'd0,  2'd1, L_S02},
        // swap rows 0 and 1
        '{I_LDA,   4'd0,  2'd0, 7'd0},
        '{I_LDB,   4'd3,  2'd0, 7'd0},
        '{I_STA,   4'd3,  2'd0, 7'd0},
        '{I_STB,   4'd0,  2'd0, 7'd0},
        '{I_LDA,   4'd1,  2'd0, 7'd0},
        '{I_LDB,   4'd4,  2'd0, 7'd0},
        '{I_STA,   4'd4,  2'd0, 7'd0},
        '{I_STB,   4'd1,  2'd0, 7'd0},
        '{I_LDA,   4'd2,  2'd0, 7'd0},
        '{I_LDB,   4'd5,  2'd0, 7'd0},
        '{I_STA,   4'd5,  2'd0, 7'd0},
        '{I_STB,   4'd2,  2'd0, 7'd0},
        '{I_PSWAP, 4'd0,  2'd0, 7'd0},
        '{I_JMP,   4'd0,  2'd0, L_C0},
        // swap rows 0 and 2
        '{I_JNE,   4'd0,  2'd2, L_C0},
        '{I_LDA,   4'd0,  2'd0, 7'd0},
        '{I_LDB,   4'd6,  2'd0, 7'd0},
        '{I_STA,   4'd6,  2'd0, 7'd0},
        '{I_STB,   4'd0,  2'd0, 7'd0},
        '{I_LDA,   4'd1,  2'd0, 7'd0},
        '{I_LDB,   4'd7,  2'd0, 7'd0},
        '{I_STA,   4'd7,  2'd0, 7'd0},
        '{I_STB,   4'd1,  2'd0, 7'd0},
        '{I_LDA,   4'd2,  2'd0, 7'd0},
        '{I_LDB,   4'd8,  2'd0, 7'd0},
        '{I_STA,   4'd8,  2'd0, 7'd0},
        '{I_STB,   4'd2,  2'd0, 7'd0},
        '{I_PSWAP, 4'd0,  2'd1, 7'd0},
        // column 0 elimination
        '{I_LDA,   4'd0,  2'd0, 7'd0},
        '{I_JNZ,   4'd0,  2'd0, L_E0},
        '{I_SING,  4'd0,  2'd0, 7'd0},
        '{I_CLR,   4'd0,  2'd0, 7'd0},
        '{I_STA,   4'd3,  2'd0, 7'd0},
        '{I_STA,   4'd6,  2'd0, 7'd0},
        '{I_JMP,   4'd0,  2'd0, L_C1},
        '{I_LDA,   4'd3,  2'd0, 7'd0},
        '{I_DIV,   4'd0,  2'd0, 7'd0},
        '{I_STA,   4'd3,  2'd0, 7'd0},
        '{I_LDB,   4'd3,  2'd0, 7'd0},
        '{I_LDA,   4'd4,  2'd0, 7'd0},
        '{I_MSUB,  4'd1,  2'd0, 7'd0},
        '{I_STA,   4'd4,  2'd0, 7'd0},
        '{I_LDA,   4'd5,  2'd0, 7'd0},
        '{I_MSUB,  4'd2,  2'd0, 7'd0},
        '{I_STA,   4'd5,  2'd0, 7'd0},
        '{I_LDA,   4'd6,  2'd0, 7'd0},
        '{I_DIV,   4'd0,  2'd0, 7'd0},
        '{I_STA,   4'd6,  2'd0, 7'd0},
        '{I_LDB,   4'd6,  2'd0, 7'd0},
        '{I_LDA,   4'd7,  2'd0, 7'd0},
        '{I_MSUB,  4'd1,  2'd0, 7'd0},
        '{I_STA,   4'd7,  2'd0, 7'd0},
        '{I_LDA,   4'd8,  2'd0, 7'd0},
        '{I_MSUB,  4'd2,  2'd0, 7'd0},
        '{I_STA,   4'd8,  2'd0, 7'd0},
        // column 1 pivot
        '{I_LDA,   4'd4,  2'd0, 7'd0},
        '{I_SEL,   4'd7,  2'd1, 7'd0},
        '{I_JNE,   4'd0,  2'd1, L_C1Z},
        '{I_LDA,   4'd3,  2'd0, 7'd0},
        '{I_LDB,   4'd6,  2'd0, 7'd0},
        '{I_STA,   4'd6,  2'd0, 7'd0},
        '{I_STB,   4'd3,  2'd0, 7'd0},
        '{I_LDA,   4'd4,  2'd0, 7'd0},
        '{I_LDB,   4'd7,  2'd0, 7'd0},
        '{I_STA,   4'd7,  2'd0, 7'd0},
        '{I_STB,   4'd4,  2'd0, 7'd0},
        '{I_LDA,   4'd5,  2'd0, 7'd0},
        '{I_LDB,   4'd8,  2'd0, 7'd0},
        '{I_STA,   4'd8,  2'd0, 7'd0},
        '{I_STB,   4'd5,  2'd0, 7'd0},
        '{I_PSWAP, 4'd0,  2'd2, 7'd0},
        // column 1 elimination
        '{I_LDA,   4'd4,  2'd0, 7'd0},
        '{I_JNZ,   4'd0,  2'd0, L_E1},
        '{I_SING,  4'd0,  2'd0, 7'd0},
        '{I_CLR,   4'd0,  2'd0, 7'd0},
        '{I_STA,   4'd7,  2'd0, 7'd0},
        '{I_JMP,   4'd0,  2'd0, 7'd88},
        '{I_LDA,   4'd7,  2'd0, 7'd0},
        '{I_DIV,   4'd4,  2'd0, 7'd0},
        '{I_STA,   4'd7,  2'd0, 7'd0},
        '{I_LDB,   4'd7,  2'd0, 7'd0},
        '{I_LDA,   4'd8,  2'd0, 7'd0},
        '{I_MSUB,  4'd5,  2'd0, 7'd0},
        '{I_STA,   4'd8,  2'd0, 7'd0},
        // last diagonal check
        '{I_LDA,   4'd8,  2'd0, 7'd0},
        '{I_JNZ,   4'd0,  2'd0, L_FEND},
        '{I_SING,  4'd0,  2'd0, 7'd0},
        '{I_END,   4'd0,  2'd0, 7'd0},
        // solve: permuted right-hand side
        '{I_LDR,   4'd0,  2'd0, 7'd0},
        '{I_STA,   4'd9,  2'd0, 7'd0},
        '{I_LDR,   4'd0,  2'd1, 7'd0},
        '{I_STA,   4'd10, 2'd0, 7'd0},
        '{I_LDR,   4'd0,  2'd2, 7'd0},
        '{I_STA,   4'd11, 2'd0, 7'd0},
        // forward substitution
        '{I_LDB,   4'd3,  2'd0, 7'd0},
        '{I_LDA,   4'd10, 2'd0, 7'd0},
        '{I_MSUB,  4'd9,  2'd0, 7'd0},
        '{I_STA,   4'd10, 2'd0, 7'd0},
        '{I_LDB,   4'd6,  2'd0, 7'd0},
        '{I_LDA,   4'd11, 2'd0, 7'd0},
        '{I_MSUB,  4'd9,  2'd0, 7'd0},
        '{I_LDB,   4'd7,  2'd0, 7'd0},
        '{I_MSUB,  4'd10, 2'd0, 7'd0},
        // back substitution
        '{I_DIV,   4'd8,  2'd0, 7'd0},
        '{I_STA,   4'd11, 2'd0, 7'd0},
        '{I_LDB,   4'd5,  2'd0, 7'd0},
        '{I_LDA,   4'd10, 2'd0, 7'd0},
        '{I_MSUB,  4'd11, 2'd0, 7'd0},
        '{I_DIV,   4'd4,  2'd0, 7'd0},
        '{I_STA,   4'd10, 2'd0, 7'd0},
        '{I_LDB,   4'd2,  2'd0, 7'd0},
        '{I_LDA,   4'd9,  2'd0, 7'd0},
        '{I_MSUB,  4'd11, 2'd0, 7'd0},
        '{I_LDB,   4'd1,  2'd0, 7'd0},
        '{I_MSUB,  4'd10, 2'd0, 7'd0},
        '{I_DIV,   4'd0,  2'd0, 7'd0},
        '{I_OUT,   4'd0,  2'd0, 7'd0},
        '{I_LDA,   4'd10, 2'd0, 7'd0},
        '{I_OUT,   4'd0,  2'd1, 7'd0},
        '{I_LDA,   4'd11, 2'd0, 7'd0},
        '{I_OUT,   4'd0,  2'd2, 7'd0},
        '{I_END,   4'd0,  2'd1, 7'd0}
    };

endpackage

>>> design/lu_solve_3x3_pivoted_unit.sv
`timescale 1ns / 1ps

// 3x3 LU factorization with partial pivoting and solve, signed fixed point with
// FRAC_BITS fraction bits held in DATA_WIDTH bits. op 0 writes one matrix entry
// and gives no result. op 1 factors the stored matrix in place and op 2 solves
// for a given right-hand side; each returns one result. Both run a fixed
// instruction sequence; each instruction passes a store read state then an
// execute state, a multiply-subtract waits on the 16-bit digit-serial
// multiplier, and a division waits on the one-bit-per-cycle restoring divider,
// which dominates. A solve while singular returns zeros without running the
// sequence. A new transaction is accepted while the previous result waits to
// be taken.
module lu_solve_3x3_pivoted_unit
    import lus3_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    lus3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in_data),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // store, arithmetic units and result register
    lus3_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

endmodule

>>> design/lus3_ctrl.sv
`timescale 1ns / 1ps

module lus3_ctrl
    import lus3_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_in   i_in,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic [6:0] r_pc, n_pc;
    t_emit r_emit, n_emit;
    t_instr ir;

    assign ir = PROG[r_pc];

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= PC_FACTOR;
            r_emit  <= EM_FACT;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_emit  <= n_emit;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_pc            = r_pc;
        n_emit          = r_emit;
        o_in_stall      = 1'b1;
        o_cmd.go        = 1'b0;
        o_cmd.code      = ir.code;
        o_cmd.addr      = ir.addr;
        o_cmd.arg       = ir.arg;
        o_cmd.start     = 1'b0;
        o_cmd.wr        = 1'b0;
        o_cmd.emit      = 1'b0;
        o_cmd.emit_kind = r_emit;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    case (i_in.op)
                        OP_WRITE: begin
                            o_cmd.wr = (i_in.entry_index < NUM_ENTRIES);
                        end
                        OP_FACTOR: begin
                            o_cmd.start = 1'b1;
                            n_pc        = PC_FACTOR;
                            n_state     = S_ISSUE;
                        end
                        OP_SOLVE: begin
                            o_cmd.start = 1'b1;
                            if (i_stat.singular) begin
                                n_emit  = EM_ZERO;
                                n_state = S_OUT;
                            end else begin
                                n_pc    = PC_SOLVE;
                                n_state = S_ISSUE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ISSUE: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.go = 1'b1;
                n_pc     = r_pc + 7'd1;
                n_state  = S_ISSUE;
                case (ir.code)
                    I_JNE: begin
                        if (i_stat.bi != ir.arg) n_pc = ir.tgt;
                    end
                    I_JNZ: begin
                        if (!i_stat.a_zero) n_pc = ir.tgt;
                    end
                    I_JMP: begin
                        n_pc = ir.tgt;
                    end
                    I_MSUB, I_DIV: begin
                        n_pc    = r_pc;
                        n_state = S_WAIT;
                    end
                    I_END: begin
                        n_pc    = r_pc;
                        n_emit  = ir.arg[0] ? EM_SOLVE : EM_FACT;
                        n_state = S_OUT;
                    end
                    default: begin
                    end
                endcase
            end
            S_WAIT: begin
                if (!i_stat.busy) begin
                    n_pc    = r_pc + 7'd1;
                    n_state = S_ISSUE;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/lus3_dp.sv
`timescale 1ns / 1ps

module lus3_dp
    import lus3_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_in,
    input  t_cmd  i_cmd,
    input  logic  i_out_stall,
    output t_stat o_stat,
    output logic  o_out_valid,
    output t_out  o_out
);

    localparam int DW  = DATA_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int ND  = (DW + 15) / 16;
    localparam int MW  = ND * 16;
    localparam int PW  = DW + MW;
    localparam int NW  = DW + FB;
    localparam int LW  = (PW > NW) ? PW : NW;
    localparam int XW  = (DW > 32) ? DW : 32;
    localparam int CW  = $clog2(ND + 1);
    localparam int DCW = $clog2(NW + 1);
    localparam int DEPTH = 12;

    localparam logic [DW-1:0] VMAXD = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] VMIND = {1'b1, {(DW-1){1'b0}}};
    localparam logic [LW-1:0] VMAX_L = {{(LW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [LW-1:0] VMIN_L = VMAX_L + 1'b1;
    localparam logic signed [XW-1:0] XMAX = XW'($signed(VMAXD));
    localparam logic signed [XW-1:0] XMIN = XW'($signed(VMIND));
    localparam logic signed [XW-1:0] I32MAX = XW'($signed(32'h7fffffff));
    localparam logic signed [XW-1:0] I32MIN = XW'($signed(32'h80000000));
    localparam logic [DW-1:0] ONE = DW'(64'd1 << FB);

    function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
        mag = v[DW-1] ? -v : v;
    endfunction

    // saturating sign and magnitude to value, msb is the saturation flag
    function automatic logic [DW:0] from_mag(input logic neg, input logic [LW-1:0] m);
        logic [DW:0] res;
        if (neg) begin
            if (m > VMIN_L) res = {1'b1, VMIND};
            else            res = {1'b0, -m[DW-1:0]};
        end else begin
            if (m > VMAX_L) res = {1'b1, VMAXD};
            else            res = {1'b0, m[DW-1:0]};
        end
        from_mag = res;
    endfunction

    function automatic logic [DW:0] sat_sub(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] d;
        logic [DW:0] res;
        d = {a[DW-1], a} - {b[DW-1], b};
        if (d[DW] != d[DW-1]) res = {1'b1, d[DW] ? VMIND : VMAXD};
        else                  res = {1'b0, d[DW-1:0]};
        sat_sub = res;
    endfunction

    function automatic logic [DW:0] clamp32(input logic [31:0] v);
        logic signed [XW-1:0] x;
        logic [DW:0] res;
        x = XW'($signed(v));
        if (x > XMAX)      res = {1'b1, VMAXD};
        else if (x < XMIN) res = {1'b1, VMIND};
        else               res = {1'b0, x[DW-1:0]};
        clamp32 = res;
    endfunction

    function automatic logic [32:0] out32(input logic [DW-1:0] a);
        logic signed [XW-1:0] x;
        logic [32:0] res;
        x = XW'($signed(a));
        if (x > I32MAX)      res = {1'b1, 32'h7fffffff};
        else if (x < I32MIN) res = {1'b1, 32'h80000000};
        else                 res = {1'b0, x[31:0]};
        out32 = res;
    endfunction

    // working store and registers
    logic [DW-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0] r_rd, r_a, r_b;
    logic [1:0] r_bi;
    logic r_sat, r_sing_acc, r_sing;
    logic [1:0] r_perm [3];
    logic [31:0] r_rhs [3];
    logic [31:0] r_sol [3];
    logic r_out_valid;
    t_out r_out;

    // multiplier state
    logic r_mul_busy, r_mneg;
    logic [CW-1:0] r_mcnt;
    logic [DW-1:0] r_mx;
    logic [MW-1:0] r_my;
    logic [PW-1:0] r_prod;

    // divider state
    logic r_div_busy, r_dneg;
    logic [DCW-1:0] r_dcnt;
    logic [DW-1:0] r_dy, r_rem;
    logic [NW-1:0] r_dnd, r_quo;

    logic [DW+15:0] mul_pp;
    logic [DW:0] mul_fm, mul_sub, div_t, div_fm, ent_cl, ldr_cl;
    logic div_ge;
    logic [31:0] ldr_raw;
    logic [32:0] out_c;
    logic [DW-1:0] rd_init;

    // arithmetic helpers
    assign mul_pp  = (DW+16)'(r_mx) * (DW+16)'(r_my[MW-1 -: 16]);
    assign mul_fm  = from_mag(r_mneg, LW'(r_prod >> FB));
    assign mul_sub = sat_sub(r_a, mul_fm[DW-1:0]);
    assign div_t   = {r_rem, r_dnd[NW-1]};
    assign div_ge  = div_t >= {1'b0, r_dy};
    assign div_fm  = from_mag(r_dneg, LW'(r_quo));
    assign ent_cl  = clamp32(i_in.entry_value);
    assign ldr_cl  = clamp32(ldr_raw);
    assign out_c   = out32(r_a);

    // right-hand side element chosen by the row order
    always_comb begin
        case (r_perm[i_cmd.arg])
            2'd1:    ldr_raw = r_rhs[1];
            2'd2:    ldr_raw = r_rhs[2];
            default: ldr_raw = r_rhs[0];
        endcase
    end

    // reset contents of entries not yet written
    always_comb begin
        case (i_cmd.addr)
            4'd0, 4'd4, 4'd8: rd_init = ONE;
            default:          rd_init = '0;
        endcase
    end

    // store write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[i_cmd.wr ? i_in.entry_index : i_cmd.addr] <= ent_cl[DW-1:0];
        end else if (i_cmd.go && i_cmd.code == I_STA) begin
            mem[i_cmd.addr] <= r_a;
        end else if (i_cmd.go && i_cmd.code == I_STB) begin
            mem[i_cmd.addr] <= r_b;
        end
    end

    // store read port and valid bits
    always_ff @(posedge i_clk) begin
        r_rd <= r_vld[i_cmd.addr] ? mem[i_cmd.addr] : rd_init;
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.wr) begin
            r_vld[i_in.entry_index] <= 1'b1;
        end else if (i_cmd.go && (i_cmd.code == I_STA || i_cmd.code == I_STB)) begin
            r_vld[i_cmd.addr] <= 1'b1;
        end
    end

    // payload registers of the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.kind       <= (i_cmd.emit_kind != EM_FACT);
            r_out.sol_0      <= r_sol[0];
            r_out.sol_1      <= r_sol[1];
            r_out.sol_2      <= r_sol[2];
            r_out.first_row  <= r_perm[0];
            r_out.second_row <= r_perm[1];
            r_out.third_row  <= r_perm[2];
            r_out.singular   <= (i_cmd.emit_kind == EM_FACT) ? r_sing_acc : r_sing;
            r_out.saturated  <= r_sat;
        end
    end

    // accumulator, units and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bi        <= 2'd0;
            r_sat       <= 1'b0;
            r_sing_acc  <= 1'b0;
            r_sing      <= 1'b0;
            r_perm[0]   <= 2'd0;
            r_perm[1]   <= 2'd1;
            r_perm[2]   <= 2'd2;
            r_out_valid <= 1'b0;
            r_mul_busy  <= 1'b0;
            r_div_busy  <= 1'b0;
            r_mcnt      <= '0;
            r_dcnt      <= '0;
        end else begin
            // output slot
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (i_cmd.emit_kind == EM_FACT) r_sing <= r_sing_acc;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // start of a transaction
            if (i_cmd.start) begin
                r_sat      <= 1'b0;
                r_sing_acc <= 1'b0;
                r_rhs[0]   <= i_in.rhs_0;
                r_rhs[1]   <= i_in.rhs_1;
                r_rhs[2]   <= i_in.rhs_2;
                r_sol[0]   <= '0;
                r_sol[1]   <= '0;
                r_sol[2]   <= '0;
            end

            // instruction execution
            if (i_cmd.go) begin
                case (i_cmd.code)
                    I_LDA: begin
                        r_a  <= r_rd;
                        r_bi <= 2'd0;
                    end
                    I_LDB: r_b <= r_rd;
                    I_SEL: begin
                        if (mag(r_rd) > mag(r_a)) begin
                            r_a  <= r_rd;
                            r_bi <= i_cmd.arg;
                        end
                    end
                    I_MSUB: begin
                        r_mx       <= mag(r_b);
                        r_my       <= MW'(mag(r_rd));
                        r_prod     <= '0;
                        r_mneg     <= r_b[DW-1] ^ r_rd[DW-1];
                        r_mcnt     <= CW'(ND);
                        r_mul_busy <= 1'b1;
                    end
                    I_DIV: begin
                        if (r_rd == '0) begin
                            if (r_a != '0) begin
                                r_a   <= r_a[DW-1] ? VMIND : VMAXD;
                                r_sat <= 1'b1;
                            end
                        end else begin
                            r_dy       <= mag(r_rd);
                            r_dnd      <= {mag(r_a), {FB{1'b0}}};
                            r_rem      <= '0;
                            r_quo      <= '0;
                            r_dneg     <= r_a[DW-1] ^ r_rd[DW-1];
                            r_dcnt     <= DCW'(NW);
                            r_div_busy <= 1'b1;
                        end
                    end
                    I_SING: r_sing_acc <= 1'b1;
                    I_CLR:  r_a <= '0;
                    I_PSWAP: begin
                        case (i_cmd.arg)
                            2'd0: begin
                                r_perm[0] <= r_perm[1];
                                r_perm[1] <= r_perm[0];
                            end
                            2'd1: begin
                                r_perm[0] <= r_perm[2];
                                r_perm[2] <= r_perm[0];
                            end
                            default: begin
                                r_perm[1] <= r_perm[2];
                                r_perm[2] <= r_perm[1];
                            end
                        endcase
                    end
                    I_LDR: begin
                        r_a <= ldr_cl[DW-1:0];
                        if (ldr_cl[DW]) r_sat <= 1'b1;
                    end
                    I_OUT: begin
                        if (i_cmd.arg != 2'd3) r_sol[i_cmd.arg] <= out_c[31:0];
                        if (out_c[32]) r_sat <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            // digit-serial multiply then subtract from the accumulator
            if (r_mul_busy) begin
                if (r_mcnt != '0) begin
                    r_prod <= (r_prod << 16) + PW'(mul_pp);
                    r_my   <= r_my << 16;
                    r_mcnt <= r_mcnt - 1'b1;
                end else begin
                    r_a        <= mul_sub[DW-1:0];
                    r_mul_busy <= 1'b0;
                    if (mul_fm[DW] || mul_sub[DW]) r_sat <= 1'b1;
                end
            end

            // restoring divider, one quotient bit per cycle
            if (r_div_busy) begin
                if (r_dcnt != '0) begin
                    r_rem  <= div_ge ? DW'(div_t - {1'b0, r_dy}) : div_t[DW-1:0];
                    r_quo  <= {r_quo[NW-2:0], div_ge};
                    r_dnd  <= r_dnd << 1;
                    r_dcnt <= r_dcnt - 1'b1;
                end else begin
                    r_a        <= div_fm[DW-1:0];
                    r_div_busy <= 1'b0;
                    if (div_fm[DW]) r_sat <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy     = r_mul_busy | r_div_busy;
    assign o_stat.a_zero   = (r_a == '0);
    assign o_stat.bi       = r_bi;
    assign o_stat.singular = r_sing;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    // one arithmetic unit at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mul_busy && r_div_busy))
        else $error("multiplier and divider active together");

    // row order stays a permutation
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_perm[0] != r_perm[1] && r_perm[0] != r_perm[2] && r_perm[1] != r_perm[2])
        else $error("row order lost an entry");

    // a result is presented after every emit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("emitted result not presented");

    // no new instruction while a unit is still running
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mul_busy || r_div_busy) |-> !i_cmd.go)
        else $error("instruction issued while unit busy");

endmodule
